>>> rtl/irpd_pkg.sv
// irpd_pkg: shared types, constants and helpers for the ir pulse distance frame encoder
// used by every module in rtl; depends on nothing
package irpd_pkg;

	localparam int TIME_BITS    = 13;
	localparam int FRAME_COPIES = 2;
	localparam int CFG_W        = 13;
	localparam int CFG_IDX_W    = 3;
	localparam int DATA_IN_W    = 24;
	localparam int DATA_OUT_W   = 8;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_LEAD_MARK  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEAD_SPACE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_SPACE = 3'd5;

	// op codes on s_tuser
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	// sequencer phases
	localparam logic [2:0] PH_IDLE       = 3'd0;
	localparam logic [2:0] PH_LEAD_MARK  = 3'd1;
	localparam logic [2:0] PH_LEAD_SPACE = 3'd2;
	localparam logic [2:0] PH_BIT_MARK   = 3'd3;
	localparam logic [2:0] PH_BIT_SPACE  = 3'd4;
	localparam logic [2:0] PH_STOP_MARK  = 3'd5;
	localparam logic [2:0] PH_STOP_SPACE = 3'd6;

	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
	localparam logic [1:0] LAST_COPY = 2'(FRAME_COPIES - 1);

	typedef struct packed {
		logic [CFG_W-1:0] lead_mark_us;
		logic [CFG_W-1:0] lead_space_us;
		logic [CFG_W-1:0] bit_mark_us;
		logic [CFG_W-1:0] zero_space_us;
		logic [CFG_W-1:0] one_space_us;
		logic [CFG_W-1:0] stop_space_us;
	} cfg_t;

	typedef struct packed {
		logic mark;
		logic busy;
		logic done;
	} res_t;

	// zero counts as one tick, values past the counter range saturate
	function automatic logic [TIME_BITS-1:0] load_time(input logic [CFG_W-1:0] v);
		logic [TIME_BITS-1:0] r;
		if (v == '0) begin
			r = TIME_BITS'(1);
		end else if (32'(v) > 32'(TIME_MAX)) begin
			r = TIME_MAX;
		end else begin
			r = TIME_BITS'(v);
		end
		return r;
	endfunction

endpackage

>>> rtl/irpd_cfg_regs.sv
// irpd_cfg_regs: six timing registers written over the configuration channel
// depends on irpd_pkg
module irpd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [irpd_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [irpd_pkg::CFG_W-1:0]     wr_data,
	output irpd_pkg::cfg_t                 cfg
);
	import irpd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lead_mark_us  <= CFG_W'(4400);
			cfg_q.lead_space_us <= CFG_W'(4400);
			cfg_q.bit_mark_us   <= CFG_W'(540);
			cfg_q.zero_space_us <= CFG_W'(540);
			cfg_q.one_space_us  <= CFG_W'(1620);
			cfg_q.stop_space_us <= CFG_W'(5220);
		end else if (wr_en) begin
			case (wr_index)
				REG_LEAD_MARK:  cfg_q.lead_mark_us  <= wr_data;
				REG_LEAD_SPACE: cfg_q.lead_space_us <= wr_data;
				REG_BIT_MARK:   cfg_q.bit_mark_us   <= wr_data;
				REG_ZERO_SPACE: cfg_q.zero_space_us <= wr_data;
				REG_ONE_SPACE:  cfg_q.one_space_us  <= wr_data;
				REG_STOP_SPACE: cfg_q.stop_space_us <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/irpd_sequencer.sv
// irpd_sequencer: frame state (phase, bit/byte position, copy count, timer, held bytes)
// and the per-item next-state and result logic; depends on irpd_pkg
module irpd_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_en,
	input  logic                 op,
	input  logic [7:0]           byte_a,
	input  logic [7:0]           byte_b,
	input  logic [7:0]           byte_c,
	input  irpd_pkg::cfg_t       cfg,
	output irpd_pkg::res_t       res
);
	import irpd_pkg::*;

	logic [2:0]           phase_q, phase_d;
	logic [2:0]           byte_pos_q, byte_pos_d;
	logic [2:0]           bit_pos_q, bit_pos_d;
	logic [1:0]           copy_q, copy_d;
	logic [TIME_BITS-1:0] time_left_q, time_left_d;
	logic [23:0]          held_q, held_d;

	logic [TIME_BITS-1:0] time_dec;
	logic [7:0]           cur_byte;
	logic                 cur_bit;
	logic                 mark_now;
	logic [1:0]           copy_inc;
	res_t                 res_d;

	function automatic logic is_mark(input logic [2:0] ph);
		return (ph == PH_LEAD_MARK) || (ph == PH_BIT_MARK) || (ph == PH_STOP_MARK);
	endfunction

	// A ~A B ~B C ~C, one byte pair per held byte
	always_comb begin
		case (byte_pos_q[2:1])
			2'd0:    cur_byte = held_q[23:16];
			2'd1:    cur_byte = held_q[15:8];
			default: cur_byte = held_q[7:0];
		endcase
		if (byte_pos_q[0]) begin
			cur_byte = ~cur_byte;
		end
		cur_bit = cur_byte[bit_pos_q];
	end

	assign time_dec = (time_left_q != '0) ? time_left_q - TIME_BITS'(1) : '0;
	assign mark_now = is_mark(phase_q);
	assign copy_inc = copy_q + 2'd1;

	always_comb begin
		phase_d     = phase_q;
		byte_pos_d  = byte_pos_q;
		bit_pos_d   = bit_pos_q;
		copy_d      = copy_q;
		time_left_d = time_left_q;
		held_d      = held_q;
		res_d       = '0;
		if (op == OP_START) begin
			if (phase_q == PH_IDLE) begin
				held_d      = {byte_a, byte_b, byte_c};
				phase_d     = PH_LEAD_MARK;
				byte_pos_d  = 3'd0;
				bit_pos_d   = 3'd7;
				copy_d      = 2'd0;
				time_left_d = load_time(cfg.lead_mark_us);
			end
			res_d.mark = is_mark(phase_d);
			res_d.busy = 1'b1;
		end else if (phase_q != PH_IDLE) begin
			res_d.mark  = mark_now;
			res_d.busy  = 1'b1;
			time_left_d = time_dec;
			if (time_dec == '0) begin
				case (phase_q)
					PH_LEAD_MARK: begin
						phase_d     = PH_LEAD_SPACE;
						time_left_d = load_time(cfg.lead_space_us);
					end
					PH_LEAD_SPACE: begin
						phase_d     = PH_BIT_MARK;
						time_left_d = load_time(cfg.bit_mark_us);
					end
					PH_BIT_MARK: begin
						phase_d     = PH_BIT_SPACE;
						time_left_d = load_time(cur_bit ? cfg.one_space_us
						                                : cfg.zero_space_us);
					end
					PH_BIT_SPACE: begin
						time_left_d = load_time(cfg.bit_mark_us);
						phase_d     = PH_BIT_MARK;
						if (bit_pos_q != 3'd0) begin
							bit_pos_d = bit_pos_q - 3'd1;
						end else begin
							bit_pos_d = 3'd7;
							if (byte_pos_q < 3'd5) begin
								byte_pos_d = byte_pos_q + 3'd1;
							end else begin
								byte_pos_d = 3'd0;
								phase_d    = PH_STOP_MARK;
							end
						end
					end
					PH_STOP_MARK: begin
						phase_d     = PH_STOP_SPACE;
						time_left_d = load_time(cfg.stop_space_us);
					end
					PH_STOP_SPACE: begin
						// last copy sent ends the frame
						if (32'(copy_inc) >= 32'(FRAME_COPIES) || copy_inc == 2'd0) begin
							phase_d     = PH_IDLE;
							time_left_d = '0;
							copy_d      = 2'd0;
							res_d.done  = 1'b1;
						end else begin
							copy_d      = copy_inc;
							phase_d     = PH_LEAD_MARK;
							time_left_d = load_time(cfg.lead_mark_us);
						end
					end
					default: begin
						phase_d     = PH_IDLE;
						time_left_d = '0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			byte_pos_q  <= 3'd0;
			bit_pos_q   <= 3'd7;
			copy_q      <= 2'd0;
			time_left_q <= '0;
			held_q      <= '0;
		end else if (item_en) begin
			phase_q     <= phase_d;
			byte_pos_q  <= byte_pos_d;
			bit_pos_q   <= bit_pos_d;
			copy_q      <= copy_d;
			time_left_q <= time_left_d;
			held_q      <= held_d;
		end
	end

	assign res = res_d;

	// a running frame always has time left on the current segment
	a_timer_live: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_IDLE |-> time_left_q != '0)
		else $error("active segment with empty timer");

	a_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_pos_q <= 3'd5)
		else $error("byte position out of range");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		item_en && res.done |-> phase_q == PH_STOP_SPACE && op == OP_TICK)
		else $error("frame end outside stop space");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		item_en && op == OP_TICK && phase_q == PH_STOP_SPACE && time_left_q == TIME_BITS'(1)
		&& copy_q == LAST_COPY |=> phase_q == PH_IDLE)
		else $error("last stop space did not return to idle");

endmodule

>>> rtl/ir_pulse_distance_frame_encoder.sv
// ir_pulse_distance_frame_encoder: top level, stream ports, config channel, result register
// an accepted item's result is registered and appears on the master side in the next cycle
// throughput: one item per cycle; input is taken while a result waits if m_tready frees the register
// reset (arst_n low, asynchronous): idle phase, default timings, output register empty
// depends on irpd_pkg, irpd_cfg_regs, irpd_sequencer
module ir_pulse_distance_frame_encoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [irpd_pkg::DATA_IN_W-1:0]  s_tdata,   // byte_a[7:0], byte_b[15:8], byte_c[23:16]
	input  logic                            s_tuser,   // op[0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [irpd_pkg::DATA_OUT_W-1:0] m_tdata,   // mark[0], busy_res[1], zero pad
	output logic                            m_tlast,   // frame_done
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [irpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [irpd_pkg::CFG_W-1:0]      cfg_data
);
	import irpd_pkg::*;

	cfg_t cfg;
	res_t res;
	res_t out_q;
	logic out_valid_q;
	logic item_en;

	assign cfg_ready = 1'b1;
	assign s_tready  = !out_valid_q || m_tready;
	assign item_en   = s_tvalid && s_tready;

	irpd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	irpd_sequencer u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_en (item_en),
		.op      (s_tuser),
		.byte_a  (s_tdata[7:0]),
		.byte_b  (s_tdata[15:8]),
		.byte_c  (s_tdata[23:16]),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_en) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_en) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(DATA_OUT_W-2){1'b0}}, out_q.busy, out_q.mark};
	assign m_tlast  = out_q.done;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted item produced no result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while result stalled");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[1] && !m_tdata[0])
		else $error("frame end without busy or with mark");

endmodule
